// ===== design/elgamal_encrypt_decrypt_macros.svh =====
// assertion shorthands, clocked on aclk and held off while aresetn is low
`ifndef ELGAMAL_ENCRYPT_DECRYPT_MACROS_SVH
`define ELGAMAL_ENCRYPT_DECRYPT_MACROS_SVH

// same-cycle implication
`define ELG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ELG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/elg_pkg.sv =====
package elg_pkg;

    localparam int WORD_BITS = 32;
    localparam int TOP_BIT   = WORD_BITS - 1;
    localparam int CNT_W     = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic {
        MODE_ENCRYPT = 1'b0,
        MODE_DECRYPT = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODULUS   = 2'd0,
        REG_GENERATOR = 2'd1,
        REG_PUBLIC    = 2'd2,
        REG_PRIVATE   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        word_t modulus;
        word_t generator;
        word_t public_value;
        word_t private_exponent;
    } cfg_t;

    typedef struct packed {
        mode_t mode;
        word_t ephemeral_exponent;
        word_t first_word;
        word_t second_word;
    } item_t;

    // request to the modular multiplier
    typedef struct packed {
        logic  start;
        word_t mul_bits;
        word_t addend;
        word_t modulus;
    } mm_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } mm_rsp_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_sts_t;

endpackage

// ===== design/elg_mulmod.sv =====
`include "elgamal_encrypt_decrypt_macros.svh"

// bit-serial interleaved modular multiply, msb of mul_bits first
module elg_mulmod import elg_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  mm_req_t req,
    output mm_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    word_t            bits_reg;
    word_t            y_reg;
    word_t            p_reg;
    word_t            r_reg;
    word_t            r_next;

    logic [WORD_BITS:0] dbl;
    logic [WORD_BITS:0] dbl_red;
    logic [WORD_BITS:0] sum;
    logic [WORD_BITS:0] sum_red;
    logic [WORD_BITS:0] p_ext;

    always_comb begin
        p_ext   = {1'b0, p_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= p_ext) ? dbl - p_ext : dbl;
        sum     = bits_reg[TOP_BIT] ? dbl_red + {1'b0, y_reg} : dbl_red;
        sum_red = (sum >= p_ext) ? sum - p_ext : sum;
        r_next  = sum_red[WORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            if (req.start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                bits_reg <= req.mul_bits;
                y_reg    <= req.addend;
                p_reg    <= req.modulus;
                r_reg    <= '0;
                cnt_reg  <= CNT_W'(WORD_BITS - 1);
            end else if (busy_reg) begin
                r_reg    <= r_next;
                bits_reg <= bits_reg << 1;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    done_reg <= 1'b0;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = r_reg;

    `ELG_ASSERT_IMP(a_start_when_free, req.start, !busy_reg, "multiply started while busy")
    `ELG_ASSERT_IMP(a_result_reduced, done_reg, r_reg < p_reg, "product not below modulus")
    `ELG_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "multiplier done held")

endmodule

// ===== design/elg_core.sv =====
`include "elgamal_encrypt_decrypt_macros.svh"

// square-and-multiply sequencer driving the shared modular multiplier
module elg_core import elg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  item_t     item,
    input  cfg_t      cfg,
    input  logic      take,
    output core_sts_t sts,
    output word_t     result_a,
    output word_t     result_b
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_FIN_GO,
        ST_FIN_WAIT,
        ST_DONE
    } state_t;

    state_t           state_reg;
    mode_t            mode_reg;
    logic             phase_reg;
    logic [CNT_W-1:0] cnt_reg;
    word_t            exp_reg;
    word_t            k_reg;
    word_t            base_reg;
    word_t            acc_reg;
    word_t            w1_reg;
    word_t            w2_reg;
    word_t            e_reg;
    word_t            p_reg;
    word_t            ra_reg;
    word_t            rb_reg;

    mm_req_t mm_req;
    mm_rsp_t mm_rsp;

    elg_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    always_comb begin
        mm_req.start   = 1'b0;
        mm_req.mul_bits = acc_reg;
        mm_req.addend  = acc_reg;
        mm_req.modulus = p_reg;
        unique case (state_reg)
            ST_SQ_GO: begin
                mm_req.start = 1'b1;
            end
            ST_MUL_GO: begin
                mm_req.start    = 1'b1;
                mm_req.mul_bits = base_reg;
            end
            ST_FIN_GO: begin
                mm_req.start    = 1'b1;
                mm_req.mul_bits = (mode_reg == MODE_ENCRYPT) ? w1_reg : w2_reg;
            end
            default: begin
                mm_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        mode_reg  <= item.mode;
                        k_reg     <= item.ephemeral_exponent;
                        w1_reg    <= item.first_word;
                        w2_reg    <= item.second_word;
                        e_reg     <= cfg.public_value;
                        p_reg     <= cfg.modulus;
                        phase_reg <= 1'b0;
                        acc_reg   <= word_t'(1);
                        cnt_reg   <= CNT_W'(WORD_BITS - 1);
                        if (item.mode == MODE_ENCRYPT) begin
                            base_reg <= cfg.generator;
                            exp_reg  <= item.ephemeral_exponent;
                        end else begin
                            base_reg <= item.first_word;
                            exp_reg  <= cfg.modulus - word_t'(1) - cfg.private_exponent;
                        end
                        // modulus zero or one: everything reduces to zero
                        if (cfg.modulus[WORD_BITS-1:1] == '0) begin
                            ra_reg    <= '0;
                            rb_reg    <= '0;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_SQ_GO;
                        end
                    end
                end
                ST_SQ_GO: begin
                    state_reg <= ST_SQ_WAIT;
                end
                ST_MUL_GO: begin
                    state_reg <= ST_MUL_WAIT;
                end
                ST_SQ_WAIT, ST_MUL_WAIT: begin
                    if (mm_rsp.done) begin
                        if (state_reg == ST_SQ_WAIT && exp_reg[TOP_BIT]) begin
                            acc_reg   <= mm_rsp.result;
                            state_reg <= ST_MUL_GO;
                        end else if (cnt_reg != '0) begin
                            acc_reg   <= mm_rsp.result;
                            exp_reg   <= exp_reg << 1;
                            cnt_reg   <= cnt_reg - 1'b1;
                            state_reg <= ST_SQ_GO;
                        end else if (mode_reg == MODE_ENCRYPT && !phase_reg) begin
                            // g^k done, start e^k
                            ra_reg    <= mm_rsp.result;
                            phase_reg <= 1'b1;
                            base_reg  <= e_reg;
                            exp_reg   <= k_reg;
                            acc_reg   <= word_t'(1);
                            cnt_reg   <= CNT_W'(WORD_BITS - 1);
                            state_reg <= ST_SQ_GO;
                        end else begin
                            acc_reg   <= mm_rsp.result;
                            exp_reg   <= exp_reg << 1;
                            state_reg <= ST_FIN_GO;
                        end
                    end
                end
                ST_FIN_GO: begin
                    state_reg <= ST_FIN_WAIT;
                end
                ST_FIN_WAIT: begin
                    if (mm_rsp.done) begin
                        if (mode_reg == MODE_ENCRYPT) begin
                            rb_reg <= mm_rsp.result;
                        end else begin
                            ra_reg <= mm_rsp.result;
                            rb_reg <= '0;
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (take) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sts.idle = (state_reg == ST_IDLE);
    assign sts.done = (state_reg == ST_DONE);
    assign result_a = ra_reg;
    assign result_b = rb_reg;

    `ELG_ASSERT_IMP(a_decrypt_b_zero, state_reg == ST_DONE && mode_reg == MODE_DECRYPT,
        rb_reg == '0, "decrypt result_b not zero")
    `ELG_ASSERT_IMP(a_acc_reduced,
        state_reg == ST_SQ_GO || state_reg == ST_MUL_GO || state_reg == ST_FIN_GO,
        acc_reg < p_reg, "accumulator not below modulus")
    `ELG_ASSERT_NXT(a_take_frees, state_reg == ST_DONE && take, state_reg == ST_IDLE,
        "core did not release after result taken")

endmodule

// ===== design/elgamal_encrypt_decrypt.sv =====
// ElGamal encrypt/decrypt over a 32-bit prime modulus p held in configuration registers.
// Encrypt (tuser 0): result_a = g^k mod p, result_b = (e^k mod p) * m mod p, with m the
// plaintext in first_word. Decrypt (tuser 1): result_a = c1^(p-1-d) * c2 mod p, with c1 in
// first_word and c2 in second_word, and result_b = 0. A modulus of 0 or 1 gives two zeros.
// Every exponentiation is left-to-right square-and-multiply over all 32 exponent bits, and
// every modular product runs on one bit-serial multiplier that takes one multiplier bit per
// cycle. An item takes 33 + popcount(exponent) products to decrypt and 65 + 2 * popcount(k)
// products to encrypt. One request is in work at a time; a finished result sits in an output
// register, so the next request is taken while the previous result waits. The registers must
// be written only while the block is idle; the block itself does not enforce it.
module elgamal_encrypt_decrypt import elg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port: 0 modulus, 1 generator, 2 public value, 3 private exponent
    input  logic                 cfg_wen,
    input  logic [1:0]           cfg_index,
    input  logic [WORD_BITS-1:0] cfg_wdata,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [3*WORD_BITS-1:0] s_tdata,  // ephemeral_exponent, first_word, second_word
    input  logic                 s_tuser,    // mode
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*WORD_BITS-1:0] m_tdata   // result_a, result_b
);

    cfg_t      cfg_reg;
    item_t     item;
    core_sts_t core_sts;
    word_t     core_ra;
    word_t     core_rb;
    logic      start;
    logic      take;
    logic      m_tvalid_reg;
    logic [2*WORD_BITS-1:0] m_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.modulus          <= word_t'(3);
            cfg_reg.generator        <= word_t'(2);
            cfg_reg.public_value     <= '0;
            cfg_reg.private_exponent <= '0;
        end else if (cfg_wen) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODULUS:   cfg_reg.modulus          <= cfg_wdata;
                REG_GENERATOR: cfg_reg.generator        <= cfg_wdata;
                REG_PUBLIC:    cfg_reg.public_value     <= cfg_wdata;
                REG_PRIVATE:   cfg_reg.private_exponent <= cfg_wdata;
                default:       cfg_reg.modulus          <= cfg_reg.modulus;
            endcase
        end
    end

    // unpack request
    assign item.mode               = mode_t'(s_tuser);
    assign item.ephemeral_exponent = s_tdata[WORD_BITS-1:0];
    assign item.first_word         = s_tdata[2*WORD_BITS-1:WORD_BITS];
    assign item.second_word        = s_tdata[3*WORD_BITS-1:2*WORD_BITS];

    assign s_tready = core_sts.idle;
    assign start    = s_tvalid && s_tready;

    // result leaves the core once the output register is free or being drained
    assign take = core_sts.done && (!m_tvalid_reg || m_tready);

    elg_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .item     (item),
        .cfg      (cfg_reg),
        .take     (take),
        .sts      (core_sts),
        .result_a (core_ra),
        .result_b (core_rb)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (take) begin
                m_tvalid_reg <= 1'b1;
                m_data_reg   <= {core_rb, core_ra};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule
